[hdl/aes128_pkg.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// AES-128 package
// Shared types, constants, the S-box tables and the GF(2^8) helpers that the
// key expansion and the round pipeline both use.
// ----------------------------------------------------------------------------
package aes128_pkg;

    localparam int unsigned CFG_IDX_W  = 1;
    localparam int unsigned CFG_DATA_W = 64;
    localparam logic [CFG_IDX_W-1:0] REG_KEY_HIGH = 1'b0;
    localparam logic [CFG_IDX_W-1:0] REG_KEY_LOW  = 1'b1;

    localparam int unsigned NUM_ROUNDS = 10;
    localparam int unsigned NUM_KEYS   = NUM_ROUNDS + 1;

    localparam logic MODE_ENC = 1'b0;
    localparam logic MODE_DEC = 1'b1;

    localparam logic [7:0] POLY_LOW = 8'h1b;

    typedef struct packed {
        logic        mode;
        logic [63:0] block_high;
        logic [63:0] block_low;
    } t_in_item;

    typedef struct packed {
        logic [63:0] result_high;
        logic [63:0] result_low;
    } t_out_item;

    typedef logic [127:0] t_state;

    typedef struct packed {
        logic   vld;
        logic   mode;
        t_state st;
    } t_stage;

    localparam logic [7:0] FWD_SBOX [256] = '{
        8'h63,8'h7c,8'h77,8'h7b,8'hf2,8'h6b,8'h6f,8'hc5,8'h30,8'h01,8'h67,8'h2b,8'hfe,8'hd7,8'hab,8'h76,
        8'hca,8'h82,8'hc9,8'h7d,8'hfa,8'h59,8'h47,8'hf0,8'had,8'hd4,8'ha2,8'haf,8'h9c,8'ha4,8'h72,8'hc0,
        8'hb7,8'hfd,8'h93,8'h26,8'h36,8'h3f,8'hf7,8'hcc,8'h34,8'ha5,8'he5,8'hf1,8'h71,8'hd8,8'h31,8'h15,
        8'h04,8'hc7,8'h23,8'hc3,8'h18,8'h96,8'h05,8'h9a,8'h07,8'h12,8'h80,8'he2,8'heb,8'h27,8'hb2,8'h75,
        8'h09,8'h83,8'h2c,8'h1a,8'h1b,8'h6e,8'h5a,8'ha0,8'h52,8'h3b,8'hd6,8'hb3,8'h29,8'he3,8'h2f,8'h84,
        8'h53,8'hd1,8'h00,8'hed,8'h20,8'hfc,8'hb1,8'h5b,8'h6a,8'hcb,8'hbe,8'h39,8'h4a,8'h4c,8'h58,8'hcf,
        8'hd0,8'hef,8'haa,8'hfb,8'h43,8'h4d,8'h33,8'h85,8'h45,8'hf9,8'h02,8'h7f,8'h50,8'h3c,8'h9f,8'ha8,
        8'h51,8'ha3,8'h40,8'h8f,8'h92,8'h9d,8'h38,8'hf5,8'hbc,8'hb6,8'hda,8'h21,8'h10,8'hff,8'hf3,8'hd2,
        8'hcd,8'h0c,8'h13,8'hec,8'h5f,8'h97,8'h44,8'h17,8'hc4,8'ha7,8'h7e,8'h3d,8'h64,8'h5d,8'h19,8'h73,
        8'h60,8'h81,8'h4f,8'hdc,8'h22,8'h2a,8'h90,8'h88,8'h46,8'hee,8'hb8,8'h14,8'hde,8'h5e,8'h0b,8'hdb,
        8'he0,8'h32,8'h3a,8'h0a,8'h49,8'h06,8'h24,8'h5c,8'hc2,8'hd3,8'hac,8'h62,8'h91,8'h95,8'he4,8'h79,
        8'he7,8'hc8,8'h37,8'h6d,8'h8d,8'hd5,8'h4e,8'ha9,8'h6c,8'h56,8'hf4,8'hea,8'h65,8'h7a,8'hae,8'h08,
        8'hba,8'h78,8'h25,8'h2e,8'h1c,8'ha6,8'hb4,8'hc6,8'he8,8'hdd,8'h74,8'h1f,8'h4b,8'hbd,8'h8b,8'h8a,
        8'h70,8'h3e,8'hb5,8'h66,8'h48,8'h03,8'hf6,8'h0e,8'h61,8'h35,8'h57,8'hb9,8'h86,8'hc1,8'h1d,8'h9e,
        8'he1,8'hf8,8'h98,8'h11,8'h69,8'hd9,8'h8e,8'h94,8'h9b,8'h1e,8'h87,8'he9,8'hce,8'h55,8'h28,8'hdf,
        8'h8c,8'ha1,8'h89,8'h0d,8'hbf,8'he6,8'h42,8'h68,8'h41,8'h99,8'h2d,8'h0f,8'hb0,8'h54,8'hbb,8'h16
    };

    localparam logic [7:0] DEC_SBOX [256] = '{
        8'h52,8'h09,8'h6a,8'hd5,8'h30,8'h36,8'ha5,8'h38,8'hbf,8'h40,8'ha3,8'h9e,8'h81,8'hf3,8'hd7,8'hfb,
        8'h7c,8'he3,8'h39,8'h82,8'h9b,8'h2f,8'hff,8'h87,8'h34,8'h8e,8'h43,8'h44,8'hc4,8'hde,8'he9,8'hcb,
        8'h54,8'h7b,8'h94,8'h32,8'ha6,8'hc2,8'h23,8'h3d,8'hee,8'h4c,8'h95,8'h0b,8'h42,8'hfa,8'hc3,8'h4e,
        8'h08,8'h2e,8'ha1,8'h66,8'h28,8'hd9,8'h24,8'hb2,8'h76,8'h5b,8'ha2,8'h49,8'h6d,8'h8b,8'hd1,8'h25,
        8'h72,8'hf8,8'hf6,8'h64,8'h86,8'h68,8'h98,8'h16,8'hd4,8'ha4,8'h5c,8'hcc,8'h5d,8'h65,8'hb6,8'h92,
        8'h6c,8'h70,8'h48,8'h50,8'hfd,8'hed,8'hb9,8'hda,8'h5e,8'h15,8'h46,8'h57,8'ha7,8'h8d,8'h9d,8'h84,
        8'h90,8'hd8,8'hab,8'h00,8'h8c,8'hbc,8'hd3,8'h0a,8'hf7,8'he4,8'h58,8'h05,8'hb8,8'hb3,8'h45,8'h06,
        8'hd0,8'h2c,8'h1e,8'h8f,8'hca,8'h3f,8'h0f,8'h02,8'hc1,8'haf,8'hbd,8'h03,8'h01,8'h13,8'h8a,8'h6b,
        8'h3a,8'h91,8'h11,8'h41,8'h4f,8'h67,8'hdc,8'hea,8'h97,8'hf2,8'hcf,8'hce,8'hf0,8'hb4,8'he6,8'h73,
        8'h96,8'hac,8'h74,8'h22,8'he7,8'had,8'h35,8'h85,8'he2,8'hf9,8'h37,8'he8,8'h1c,8'h75,8'hdf,8'h6e,
        8'h47,8'hf1,8'h1a,8'h71,8'h1d,8'h29,8'hc5,8'h89,8'h6f,8'hb7,8'h62,8'h0e,8'haa,8'h18,8'hbe,8'h1b,
        8'hfc,8'h56,8'h3e,8'h4b,8'hc6,8'hd2,8'h79,8'h20,8'h9a,8'hdb,8'hc0,8'hfe,8'h78,8'hcd,8'h5a,8'hf4,
        8'h1f,8'hdd,8'ha8,8'h33,8'h88,8'h07,8'hc7,8'h31,8'hb1,8'h12,8'h10,8'h59,8'h27,8'h80,8'hec,8'h5f,
        8'h60,8'h51,8'h7f,8'ha9,8'h19,8'hb5,8'h4a,8'h0d,8'h2d,8'he5,8'h7a,8'h9f,8'h93,8'hc9,8'h9c,8'hef,
        8'ha0,8'he0,8'h3b,8'h4d,8'hae,8'h2a,8'hf5,8'hb0,8'hc8,8'heb,8'hbb,8'h3c,8'h83,8'h53,8'h99,8'h61,
        8'h17,8'h2b,8'h04,8'h7e,8'hba,8'h77,8'hd6,8'h26,8'he1,8'h69,8'h14,8'h63,8'h55,8'h21,8'h0c,8'h7d
    };

    function automatic logic [7:0] xtime(input logic [7:0] v);
        return {v[6:0], 1'b0} ^ (v[7] ? POLY_LOW : 8'h00);
    endfunction

    function automatic logic [31:0] sub_word(input logic [31:0] w);
        return {FWD_SBOX[w[31:24]], FWD_SBOX[w[23:16]], FWD_SBOX[w[15:8]], FWD_SBOX[w[7:0]]};
    endfunction

endpackage : aes128_pkg
`default_nettype wire

[hdl/aes128_block_cipher_top.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// AES-128 block cipher
// Fully unrolled ten-round encrypt/decrypt pipeline with on-chip key expansion.
// ----------------------------------------------------------------------------
// The engine accepts one 128-bit block per cycle while the output is not
// stalled. A block passes through the input register, loaded by the edge that
// accepts it, then ten round stages, the last of which is the output
// register; results leave in order. The whole pipeline advances only when the
// output register is empty or being taken, so a stall holds every stage.
// After reset or after a write to either key register, the key schedule
// spends cycles refilling the round keys; write the key only while the
// engine is idle and wait those cycles before sending blocks.
module aes128_block_cipher_top (
    input  wire logic                               i_clk,
    input  wire logic                               i_rst_n,
    input  wire logic                               i_cfg_we,
    input  wire logic [aes128_pkg::CFG_IDX_W-1:0]   i_cfg_idx,
    input  wire logic [aes128_pkg::CFG_DATA_W-1:0]  i_cfg_data,
    input  wire logic                               i_valid,
    output logic                                    o_ready,
    input  wire aes128_pkg::t_in_item               i_data,
    output logic                                    o_valid,
    input  wire logic                               i_ready,
    output aes128_pkg::t_out_item                   o_data
);
    import aes128_pkg::*;

    logic [NUM_KEYS-1:0][127:0] rk;
    t_stage stg [NUM_ROUNDS+1];
    logic   r_in_vld;
    logic   r_in_mode;
    t_state r_in_st;
    logic   adv;

    // Every stage moves together; the last stage doubles as the output register.
    assign adv     = !stg[NUM_ROUNDS].vld || i_ready;
    assign o_ready = adv;

    aes128_key_exp u_key (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg_we     (i_cfg_we),
        .i_cfg_idx    (i_cfg_idx),
        .i_cfg_data   (i_cfg_data),
        .o_round_keys (rk)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_vld <= 1'b0;
        end else if (adv) begin
            r_in_vld <= i_valid;
        end
    end

    // Initial AddRoundKey: key 0 for encrypt, key 10 for decrypt.
    always_ff @(posedge i_clk) begin
        if (adv) begin
            r_in_mode <= i_data.mode;
            r_in_st   <= {i_data.block_high, i_data.block_low} ^
                         (i_data.mode == MODE_DEC ? rk[NUM_ROUNDS] : rk[0]);
        end
    end

    assign stg[0] = '{vld: r_in_vld, mode: r_in_mode, st: r_in_st};

    for (genvar g = 1; g <= NUM_ROUNDS; g++) begin : g_rnd
        aes128_round #(.LAST(g == NUM_ROUNDS)) u_rnd (
            .i_clk     (i_clk),
            .i_rst_n   (i_rst_n),
            .i_en      (adv),
            .i_stg     (stg[g-1]),
            .i_enc_key (rk[g]),
            .i_dec_key (rk[NUM_ROUNDS-g]),
            .o_stg     (stg[g])
        );
    end

    assign o_valid = stg[NUM_ROUNDS].vld;
    assign o_data  = t_out_item'(stg[NUM_ROUNDS].st);

`ifndef SYNTHESIS
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !i_ready |=> o_valid && $stable(o_data)) else $error("output dropped");
    a_ready: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_valid |-> o_ready) else $error("empty pipeline stalled");
    a_flow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_ready && !i_valid |=> !r_in_vld) else $error("bubble became an item");
`endif
endmodule : aes128_block_cipher_top
`default_nettype wire

[hdl/aes128_key_exp.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// AES-128 key expansion
// Holds the cipher key and expands it one round key per cycle into a bank of
// eleven 128-bit round-key registers, restarting whenever a key word is written.
// ----------------------------------------------------------------------------
module aes128_key_exp (
    input  wire logic                               i_clk,
    input  wire logic                               i_rst_n,
    input  wire logic                               i_cfg_we,
    input  wire logic [aes128_pkg::CFG_IDX_W-1:0]   i_cfg_idx,
    input  wire logic [aes128_pkg::CFG_DATA_W-1:0]  i_cfg_data,
    output logic [aes128_pkg::NUM_KEYS-1:0][127:0]  o_round_keys
);
    import aes128_pkg::*;

    localparam int unsigned CNT_W = $clog2(NUM_KEYS + 1);

    logic [63:0]  r_key_high, r_key_low;
    logic [CNT_W-1:0] r_cnt;
    logic [7:0]   r_rcon;
    logic [127:0] r_prev;
    logic [NUM_KEYS-1:0][127:0] r_rk;
    logic [127:0] n_next;
    logic [31:0]  w0, w1, w2, w3, t;

    // One round key per cycle; the chain is a handful of XORs and four S-box lookups.
    always_comb begin
        t  = sub_word({r_prev[23:0], r_prev[31:24]}) ^ {r_rcon, 24'h0};
        w0 = r_prev[127:96] ^ t;
        w1 = r_prev[95:64] ^ w0;
        w2 = r_prev[63:32] ^ w1;
        w3 = r_prev[31:0] ^ w2;
        n_next = {w0, w1, w2, w3};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_key_high <= '0;
            r_key_low  <= '0;
            r_cnt      <= '0;
            r_rcon     <= 8'h01;
            r_prev     <= '0;
        end else if (i_cfg_we) begin
            if (i_cfg_idx == REG_KEY_HIGH) begin
                r_key_high <= i_cfg_data;
                r_prev     <= {i_cfg_data, r_key_low};
            end else begin
                r_key_low <= i_cfg_data;
                r_prev    <= {r_key_high, i_cfg_data};
            end
            r_cnt  <= '0;
            r_rcon <= 8'h01;
        end else if (r_cnt < CNT_W'(NUM_KEYS)) begin
            r_cnt <= r_cnt + 1'b1;
            if (r_cnt != '0) begin
                r_prev <= n_next;
                r_rcon <= xtime(r_rcon);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_cnt == '0) begin
            r_rk[0] <= r_prev;
        end
        for (int k = 1; k < NUM_KEYS; k++) begin
            if (r_cnt == CNT_W'(k)) begin
                r_rk[k] <= n_next;
            end
        end
    end

    assign o_round_keys = r_rk;

`ifndef SYNTHESIS
    a_cnt_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cnt <= CNT_W'(NUM_KEYS)) else $error("key counter overran");
    a_restart: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cfg_we |=> r_cnt == '0) else $error("key write did not restart expansion");
    a_rcon_first: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cnt == '0 |-> r_rcon == 8'h01) else $error("round constant not reset");
`endif
endmodule : aes128_key_exp
`default_nettype wire

[hdl/aes128_round.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// AES-128 round stage
// One registered round of either direction. Encrypt: SubBytes, ShiftRows,
// MixColumns (skipped in the last round), AddRoundKey. Decrypt: InvShiftRows,
// InvSubBytes, AddRoundKey, InvMixColumns (skipped in the last round).
// ----------------------------------------------------------------------------
module aes128_round #(
    parameter bit LAST = 1'b0
) (
    input  wire logic                i_clk,
    input  wire logic                i_rst_n,
    input  wire logic                i_en,
    input  wire aes128_pkg::t_stage  i_stg,
    input  wire logic [127:0]        i_enc_key,
    input  wire logic [127:0]        i_dec_key,
    output aes128_pkg::t_stage       o_stg
);
    import aes128_pkg::*;

    logic   r_vld;
    logic   r_mode;
    t_state r_st;
    t_state n_st, sb_e, sr_e, mc_e, sr_d, sb_d, ak_d, mc_d;

    function automatic logic [31:0] mix_fwd(input logic [31:0] c);
        logic [7:0] a0, a1, a2, a3;
        a0 = c[31:24]; a1 = c[23:16]; a2 = c[15:8]; a3 = c[7:0];
        return {xtime(a0) ^ xtime(a1) ^ a1 ^ a2 ^ a3,
                a0 ^ xtime(a1) ^ xtime(a2) ^ a2 ^ a3,
                a0 ^ a1 ^ xtime(a2) ^ xtime(a3) ^ a3,
                xtime(a0) ^ a0 ^ a1 ^ a2 ^ xtime(a3)};
    endfunction

    // The 0e/0b/0d/09 products are built from the 2x, 4x and 8x xtime chain.
    function automatic logic [31:0] mix_inv(input logic [31:0] c);
        logic [7:0] a [4];
        logic [7:0] x2 [4];
        logic [7:0] x4 [4];
        logic [7:0] x8 [4];
        logic [7:0] m9 [4];
        logic [7:0] mb [4];
        logic [7:0] md [4];
        logic [7:0] me [4];
        logic [31:0] r;
        for (int j = 0; j < 4; j++) begin
            a[j]  = c[31-8*j -: 8];
            x2[j] = xtime(a[j]);
            x4[j] = xtime(x2[j]);
            x8[j] = xtime(x4[j]);
            m9[j] = x8[j] ^ a[j];
            mb[j] = x8[j] ^ x2[j] ^ a[j];
            md[j] = x8[j] ^ x4[j] ^ a[j];
            me[j] = x8[j] ^ x4[j] ^ x2[j];
        end
        for (int rr = 0; rr < 4; rr++) begin
            r[31-8*rr -: 8] = me[rr] ^ mb[(rr+1)%4] ^ md[(rr+2)%4] ^ m9[(rr+3)%4];
        end
        return r;
    endfunction

    always_comb begin
        for (int i = 0; i < 16; i++) begin
            sb_e[127-8*i -: 8] = FWD_SBOX[i_stg.st[127-8*i -: 8]];
        end
        // Byte s[r + 4c] sits at bits 127-8*(r+4c).
        for (int rr = 0; rr < 4; rr++) begin
            for (int c = 0; c < 4; c++) begin
                sr_e[127-8*(rr+4*c) -: 8] = sb_e[127-8*(rr+4*((c+rr)%4)) -: 8];
                sr_d[127-8*(rr+4*c) -: 8] = i_stg.st[127-8*(rr+4*((c+4-rr)%4)) -: 8];
            end
        end
        for (int c = 0; c < 4; c++) begin
            mc_e[127-32*c -: 32] = mix_fwd(sr_e[127-32*c -: 32]);
        end
        for (int i = 0; i < 16; i++) begin
            sb_d[127-8*i -: 8] = DEC_SBOX[sr_d[127-8*i -: 8]];
        end
        ak_d = sb_d ^ i_dec_key;
        for (int c = 0; c < 4; c++) begin
            mc_d[127-32*c -: 32] = mix_inv(ak_d[127-32*c -: 32]);
        end
        if (i_stg.mode == MODE_ENC) begin
            n_st = (LAST ? sr_e : mc_e) ^ i_enc_key;
        end else begin
            n_st = LAST ? ak_d : mc_d;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= 1'b0;
        end else if (i_en) begin
            r_vld <= i_stg.vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_mode <= i_stg.mode;
            r_st   <= n_st;
        end
    end

    assign o_stg = '{vld: r_vld, mode: r_mode, st: r_st};
endmodule : aes128_round
`default_nettype wire

[bench/aes128_block_cipher_checker.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// AES-128 block cipher checker
// Watches the key register port and both data channels. It keeps its own key
// schedule and predicts each result block, then compares every output
// transaction in order against the oldest predicted block.
// ----------------------------------------------------------------------------
module aes128_block_cipher_checker (
    input  wire logic                               i_clk,
    input  wire logic                               i_rst_n,
    input  wire logic                               i_cfg_we,
    input  wire logic [aes128_pkg::CFG_IDX_W-1:0]   i_cfg_idx,
    input  wire logic [aes128_pkg::CFG_DATA_W-1:0]  i_cfg_data,
    input  wire logic                               i_valid,
    input  wire logic                               i_ready_in,
    input  wire aes128_pkg::t_in_item               i_data,
    input  wire logic                               i_out_valid,
    input  wire logic                               i_out_ready,
    input  wire aes128_pkg::t_out_item              i_out_data,
    output int                                      o_fail_count,
    output int                                      o_pending,
    output int                                      o_enc_count,
    output int                                      o_dec_count
);
    import aes128_pkg::*;

    logic [63:0] key_hi = '0;
    logic [63:0] key_lo = '0;
    logic [31:0] sched [44];
    t_out_item   expected_blocks [$];

    function automatic logic [7:0] mul2(input logic [7:0] v);
        return {v[6:0], 1'b0} ^ (v[7] ? 8'h1b : 8'h00);
    endfunction

    function automatic logic [7:0] gmul(input logic [7:0] a, input logic [7:0] b);
        logic [7:0] acc;
        acc = '0;
        for (int i = 0; i < 8; i++) begin
            if (b[i]) acc ^= a;
            a = mul2(a);
        end
        return acc;
    endfunction

    function automatic void expand_schedule();
        logic [7:0]  rcon;
        logic [31:0] t;
        rcon = 8'h01;
        sched[0] = key_hi[63:32];
        sched[1] = key_hi[31:0];
        sched[2] = key_lo[63:32];
        sched[3] = key_lo[31:0];
        for (int i = 4; i < 44; i++) begin
            t = sched[i-1];
            if (i % 4 == 0) begin
                t = {t[23:0], t[31:24]};
                t = {FWD_SBOX[t[31:24]], FWD_SBOX[t[23:16]],
                     FWD_SBOX[t[15:8]], FWD_SBOX[t[7:0]]} ^ {rcon, 24'h0};
                rcon = mul2(rcon);
            end
            sched[i] = sched[i-4] ^ t;
        end
    endfunction

    // Bytes are held column-major: byte r of column c sits at index r + 4c.
    function automatic t_out_item cipher_block(input t_in_item it);
        logic [7:0] s [16];
        logic [7:0] t [16];
        logic [7:0] a [4];
        logic [7:0] m [4];
        int         dir, rnd, step;
        t_out_item  res;
        for (int i = 0; i < 8; i++) begin
            s[i]     = it.block_high[63-8*i -: 8];
            s[8+i]   = it.block_low[63-8*i -: 8];
        end
        dir = (it.mode == MODE_ENC) ? 1 : -1;
        if (it.mode == MODE_ENC) m = '{8'h02, 8'h03, 8'h01, 8'h01};
        else m = '{8'h0e, 8'h0b, 8'h0d, 8'h09};
        rnd = (it.mode == MODE_ENC) ? 0 : NUM_ROUNDS;
        for (step = 0; step <= NUM_ROUNDS; step++) begin
            if (step > 0) begin
                // Substitution and row rotation commute, so one order serves both.
                for (int i = 0; i < 16; i++)
                    s[i] = (it.mode == MODE_ENC) ? FWD_SBOX[s[i]] : DEC_SBOX[s[i]];
                for (int r = 0; r < 4; r++)
                    for (int c = 0; c < 4; c++)
                        t[r+4*c] = s[r + 4*((c + dir*r + 8) % 4)];
                s = t;
                // The forward cipher mixes before its round key, the inverse after.
                if (it.mode == MODE_ENC && step < NUM_ROUNDS) begin
                    for (int c = 0; c < 4; c++) begin
                        for (int j = 0; j < 4; j++) a[j] = s[4*c+j];
                        for (int r = 0; r < 4; r++) begin
                            s[4*c+r] = '0;
                            for (int j = 0; j < 4; j++)
                                s[4*c+r] ^= gmul(a[j], m[(j - r + 4) % 4]);
                        end
                    end
                end
            end
            for (int c = 0; c < 4; c++)
                for (int k = 0; k < 4; k++)
                    s[4*c+k] ^= sched[rnd*4+c][31-8*k -: 8];
            if (it.mode == MODE_DEC && step > 0 && step < NUM_ROUNDS) begin
                for (int c = 0; c < 4; c++) begin
                    for (int j = 0; j < 4; j++) a[j] = s[4*c+j];
                    for (int r = 0; r < 4; r++) begin
                        s[4*c+r] = '0;
                        for (int j = 0; j < 4; j++)
                            s[4*c+r] ^= gmul(a[j], m[(j - r + 4) % 4]);
                    end
                end
            end
            rnd += dir;
        end
        for (int i = 0; i < 8; i++) begin
            res.result_high[63-8*i -: 8] = s[i];
            res.result_low[63-8*i -: 8]  = s[8+i];
        end
        return res;
    endfunction

    initial begin
        o_fail_count = 0;
        o_enc_count  = 0;
        o_dec_count  = 0;
        expand_schedule();
    end

    assign o_pending = expected_blocks.size();

    always @(posedge i_clk) begin
        t_out_item want;
        if (!i_rst_n) begin
            key_hi = '0;
            key_lo = '0;
            expand_schedule();
        end else begin
            if (i_cfg_we) begin
                if (i_cfg_idx == REG_KEY_HIGH) key_hi = i_cfg_data;
                else if (i_cfg_idx == REG_KEY_LOW) key_lo = i_cfg_data;
                expand_schedule();
            end
            if (i_valid && i_ready_in) begin
                expected_blocks.push_back(cipher_block(i_data));
                if (i_data.mode == MODE_ENC) o_enc_count++;
                else o_dec_count++;
            end
            if (i_out_valid && i_out_ready) begin
                if (expected_blocks.size() == 0) begin
                    $display("%0t: unexpected result transaction %h", $time, i_out_data);
                    o_fail_count++;
                end else begin
                    want = expected_blocks.pop_front();
                    if (want.result_high !== i_out_data.result_high) begin
                        $display("%0t: result_high expected %h actual %h", $time,
                                 want.result_high, i_out_data.result_high);
                        o_fail_count++;
                    end
                    if (want.result_low !== i_out_data.result_low) begin
                        $display("%0t: result_low expected %h actual %h", $time,
                                 want.result_low, i_out_data.result_low);
                        o_fail_count++;
                    end
                end
            end
        end
    end

endmodule

[bench/aes128_block_cipher_top_tb.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// AES-128 block cipher testbench
// Drives known-answer and random blocks in both directions under several
// keys, with random idling on both channels and one long output stall.
// ----------------------------------------------------------------------------
module aes128_block_cipher_top_tb;
    import aes128_pkg::*;

    localparam int SETTLE_CYCLES = 20;

    logic                   i_clk = 1'b0;
    logic                   i_rst_n = 1'b0;
    logic                   i_cfg_we = 1'b0;
    logic [CFG_IDX_W-1:0]   i_cfg_idx = REG_KEY_HIGH;
    logic [CFG_DATA_W-1:0]  i_cfg_data = '0;
    logic                   i_valid = 1'b0;
    logic                   o_ready;
    t_in_item               i_data = '0;
    logic                   o_valid;
    logic                   i_ready = 1'b0;
    t_out_item              o_data;

    int  fail_count, pending, enc_count, dec_count;
    bit  steady = 1'b0;
    bit  stall_req = 1'b0;
    int  key_count = 1;

    always #10 i_clk = ~i_clk;

    aes128_block_cipher_top u_top (
        .i_clk, .i_rst_n, .i_cfg_we, .i_cfg_idx, .i_cfg_data,
        .i_valid, .o_ready, .i_data, .o_valid, .i_ready, .o_data
    );

    aes128_block_cipher_checker u_checker (
        .i_clk, .i_rst_n, .i_cfg_we, .i_cfg_idx, .i_cfg_data,
        .i_valid, .i_ready_in(o_ready), .i_data,
        .i_out_valid(o_valid), .i_out_ready(i_ready), .i_out_data(o_data),
        .o_fail_count(fail_count), .o_pending(pending),
        .o_enc_count(enc_count), .o_dec_count(dec_count)
    );

    function automatic bit idle_now();
        return !steady && ($urandom_range(99) < 24);
    endfunction

    // Receiver: random back-pressure, plus a long hold-off when requested.
    initial begin
        forever begin
            @(posedge i_clk);
            if (stall_req) begin
                stall_req = 1'b0;
                i_ready <= 1'b0;
                repeat (300) @(posedge i_clk);
            end
            i_ready <= !idle_now();
        end
    end

    // Valid stays high across back-to-back transactions; it drops only to idle.
    task automatic send_block(input t_in_item blk);
        while (idle_now()) begin
            i_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_valid <= 1'b1;
        i_data  <= blk;
        do @(posedge i_clk); while (!o_ready);
    endtask

    task automatic send_random(input int count);
        t_in_item blk;
        repeat (count) begin
            blk.mode       = $urandom_range(1);
            blk.block_high = {$urandom, $urandom};
            blk.block_low  = {$urandom, $urandom};
            send_block(blk);
        end
    endtask

    task automatic drain();
        i_valid <= 1'b0;
        @(posedge i_clk);
        while (pending != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic load_key(input logic [63:0] hi, input logic [63:0] lo);
        drain();
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= REG_KEY_HIGH;
        i_cfg_data <= hi;
        @(posedge i_clk);
        i_cfg_idx  <= REG_KEY_LOW;
        i_cfg_data <= lo;
        @(posedge i_clk);
        i_cfg_we   <= 1'b0;
        // The key schedule refills before any block may enter.
        repeat (SETTLE_CYCLES) @(posedge i_clk);
        key_count++;
    endtask

    task automatic send_both(input logic [63:0] hi, input logic [63:0] lo);
        send_block('{MODE_ENC, hi, lo});
        send_block('{MODE_DEC, hi, lo});
    endtask

    initial begin
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;
        repeat (SETTLE_CYCLES) @(posedge i_clk);

        // Directed blocks under the all-zero reset key.
        send_both('0, '0);
        send_both('1, '1);
        send_both(64'haaaa_aaaa_aaaa_aaaa, 64'h5555_5555_5555_5555);
        send_both(64'h8000_0000_0000_0000, 64'h0000_0000_0000_0001);

        // Standard known-answer vector.
        load_key(64'h0001_0203_0405_0607, 64'h0809_0a0b_0c0d_0e0f);
        send_block('{MODE_ENC, 64'h0011_2233_4455_6677, 64'h8899_aabb_ccdd_eeff});
        send_block('{MODE_DEC, 64'h69c4_e0d8_6a7b_0430, 64'hd8cd_b780_70b4_c55a});
        send_both('0, '1);
        send_both('1, '0);

        load_key('1, '1);
        send_both('0, '0);
        send_both('1, '1);
        send_random(150);

        load_key('0, '0);
        steady = 1'b1;
        send_random(150);
        steady = 1'b0;

        load_key({$urandom, $urandom}, {$urandom, $urandom});
        stall_req = 1'b1;
        send_random(180);

        repeat (3) begin
            load_key({$urandom, $urandom}, {$urandom, $urandom});
            send_random(120);
        end

        drain();
        $display("Covered %0d encrypt and %0d decrypt blocks under %0d keys,",
                 enc_count, dec_count, key_count);
        $display("including a long output stall and an idle-free stretch.");
        if (fail_count == 0 && pending == 0) begin
            $display("TEST PASSED");
        end else begin
            $display("TEST FAILED");
        end
        $finish;
    end

    initial begin
        #5ms;
        $display("Timeout with %0d results outstanding.", pending);
        $display("TEST FAILED");
        $finish;
    end

endmodule

[aes128_block_cipher_top.f]
hdl/aes128_pkg.sv
hdl/aes128_key_exp.sv
hdl/aes128_round.sv
hdl/aes128_block_cipher_top.sv
bench/aes128_block_cipher_checker.sv
bench/aes128_block_cipher_top_tb.sv
